// ===== src/sps_pkg.sv =====
// shared types and constants of the segmented prime sieve counter
`default_nettype none
package sps_pkg;

  localparam int N_W    = 24;
  localparam int IDX_W  = 10;
  localparam int TOT_W  = 11;
  localparam int CNT_W  = 21;
  localparam int ROOT_W = 13;
  localparam int SQ_W   = 25;
  localparam int DVD_W  = 25;
  localparam int DVS_W  = 13;

  localparam int BASE_DEPTH_DEF    = 4096;
  localparam int SEGMENT_DEPTH_DEF = 65536;

  localparam logic [ROOT_W-1:0] FIRST_ODD = ROOT_W'(3);

  typedef struct packed {
    logic [N_W-1:0]   upper_limit;
    logic [IDX_W-1:0] segment_index;
    logic [TOT_W-1:0] segment_total;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] odd_prime_count;
    logic             job_error;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/sps_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module sps_divider import sps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] acc_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, acc_q[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      acc_q <= {acc_q[DVD_W-2:0], fits};
      rem_q <= fits ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = acc_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== src/sps_engine.sv =====
// sieve sequencer with the base and segment mark memories
`default_nettype none
module sps_engine import sps_pkg::*; #(
  parameter int BASE_DEPTH    = BASE_DEPTH_DEF,
  parameter int SEGMENT_DEPTH = SEGMENT_DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire in_item_t job_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output out_item_t     res_o,
  input  wire logic     res_ready_i,
  output div_req_t      div_req_o,
  input  wire div_rsp_t div_rsp_i
);

  localparam int BAW   = $clog2(BASE_DEPTH);
  localparam int SAW   = $clog2(SEGMENT_DEPTH);
  localparam int LEN_W = SAW + 1;
  localparam int KW    = ((LEN_W > ROOT_W) ? LEN_W : ROOT_W) + 1;

  typedef enum logic [3:0] {
    IDLE, ROOT, DIVB, MUL, BOUNDS, CLEAR, BREAD, BCHK, BSQ, BMARK,
    SEG, SDIV, SMARK, SCAN, SCHK, FIN
  } state_e;

  state_e             state_q;
  logic [N_W-1:0]     n_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TOT_W-1:0]   tot_q;
  logic               last_q;
  logic [ROOT_W-1:0]  r_q;
  logic [SQ_W-1:0]    sq_q;
  logic [N_W-1:0]     blk_q;
  logic [TOT_W-1:0]   srem_q;
  logic [N_W-1:0]     off_q;
  logic [DVD_W-1:0]   lo_q;
  logic [LEN_W-1:0]   len_q;
  logic [ROOT_W-1:0]  i_q;
  logic [2*ROOT_W-1:0] prod_q;
  logic [KW-1:0]      k_q;
  logic [CNT_W-1:0]   count_q;
  logic               err_q;

  logic [DVD_W-1:0] lo_raw, lo_odd, hi_val, len_full;
  logic             root_done;

  logic           base_mem [BASE_DEPTH];
  logic           seg_mem  [SEGMENT_DEPTH];
  logic           base_rd_q, seg_rd_q;
  logic           base_we, base_wd, seg_we, seg_wd;
  logic [BAW-1:0] base_wa, base_ra;
  logic [SAW-1:0] seg_wa, seg_ra;

  assign root_done = sq_q >= {1'b0, n_q};
  assign lo_raw    = DVD_W'(off_q) + DVD_W'(r_q) + DVD_W'(1);
  assign lo_odd    = {lo_raw[DVD_W-1:1], 1'b1};
  assign hi_val    = DVD_W'(off_q) + DVD_W'(r_q) + DVD_W'(blk_q)
                   + (last_q ? DVD_W'(srem_q) : '0);
  assign len_full  = (hi_val >= lo_odd) ? (hi_val - lo_odd + DVD_W'(1)) : '0;

  always_comb begin
    base_we = 1'b0;
    base_wd = 1'b0;
    base_wa = BAW'(k_q);
    base_ra = BAW'(i_q);
    seg_we  = 1'b0;
    seg_wd  = 1'b0;
    seg_wa  = SAW'(k_q);
    seg_ra  = SAW'(k_q);
    div_req_o.start    = 1'b0;
    div_req_o.dividend = DVD_W'(n_q - N_W'(r_q));
    div_req_o.divisor  = DVS_W'(tot_q);
    unique case (state_q)
      ROOT: div_req_o.start = root_done && (32'(r_q) < BASE_DEPTH);
      CLEAR: begin
        base_we = k_q <= KW'(r_q);
        seg_we  = k_q < KW'(len_q);
      end
      BMARK: begin
        base_we = k_q <= KW'(r_q);
        base_wd = 1'b1;
      end
      SEG: begin
        div_req_o.start    = len_q != '0;
        div_req_o.dividend = lo_q;
        div_req_o.divisor  = DVS_W'(i_q);
      end
      SMARK: begin
        seg_we = k_q < KW'(len_q);
        seg_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (base_we) base_mem[base_wa] <= base_wd;
    base_rd_q <= base_mem[base_ra];
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    seg_rd_q <= seg_mem[seg_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      count_q <= '0;
      err_q   <= 1'b0;
    end else begin
      unique case (state_q)
        IDLE: if (start_i) begin
          n_q    <= job_i.upper_limit;
          idx_q  <= job_i.segment_index;
          tot_q  <= job_i.segment_total;
          last_q <= TOT_W'(job_i.segment_index) + TOT_W'(1) == job_i.segment_total;
          r_q    <= '0;
          sq_q   <= '0;
          if (TOT_W'(job_i.segment_index) >= job_i.segment_total) begin
            count_q <= '0;
            err_q   <= 1'b1;
            state_q <= FIN;
          end else begin
            state_q <= ROOT;
          end
        end
        ROOT: begin
          if (!root_done) begin
            r_q  <= r_q + ROOT_W'(1);
            sq_q <= sq_q + SQ_W'({r_q, 1'b1});
          end else if (32'(r_q) >= BASE_DEPTH) begin
            count_q <= '0;
            err_q   <= 1'b1;
            state_q <= FIN;
          end else begin
            state_q <= DIVB;
          end
        end
        DIVB: if (div_rsp_i.done) begin
          blk_q   <= div_rsp_i.quo[N_W-1:0];
          srem_q  <= TOT_W'(div_rsp_i.rem);
          state_q <= MUL;
        end
        MUL: begin
          off_q   <= N_W'(blk_q * idx_q);
          state_q <= BOUNDS;
        end
        BOUNDS: begin
          if (len_full > DVD_W'(SEGMENT_DEPTH)) begin
            count_q <= '0;
            err_q   <= 1'b1;
            state_q <= FIN;
          end else begin
            lo_q    <= lo_odd;
            len_q   <= LEN_W'(len_full);
            k_q     <= '0;
            count_q <= '0;
            err_q   <= 1'b0;
            state_q <= CLEAR;
          end
        end
        CLEAR: begin
          k_q <= k_q + KW'(1);
          if (k_q >= KW'(r_q) && k_q + KW'(1) >= KW'(len_q)) begin
            i_q     <= FIRST_ODD;
            state_q <= BREAD;
          end
        end
        BREAD: begin
          if (i_q > r_q) begin
            k_q     <= '0;
            state_q <= SCAN;
          end else begin
            state_q <= BCHK;
          end
        end
        BCHK: begin
          if (base_rd_q) begin
            i_q     <= i_q + ROOT_W'(2);
            state_q <= BREAD;
          end else begin
            if (idx_q == '0) count_q <= count_q + CNT_W'(1);
            prod_q  <= i_q * i_q;
            state_q <= BSQ;
          end
        end
        BSQ: begin
          k_q     <= KW'(prod_q);
          state_q <= (prod_q > (2*ROOT_W)'(r_q)) ? SEG : BMARK;
        end
        BMARK: begin
          if (k_q > KW'(r_q)) state_q <= SEG;
          else k_q <= k_q + KW'(i_q);
        end
        SEG: begin
          if (len_q == '0) begin
            i_q     <= i_q + ROOT_W'(2);
            state_q <= BREAD;
          end else begin
            state_q <= SDIV;
          end
        end
        SDIV: if (div_rsp_i.done) begin
          k_q     <= (div_rsp_i.rem == '0) ? '0 : KW'(i_q - ROOT_W'(div_rsp_i.rem));
          state_q <= SMARK;
        end
        SMARK: begin
          if (k_q >= KW'(len_q)) begin
            i_q     <= i_q + ROOT_W'(2);
            state_q <= BREAD;
          end else begin
            k_q <= k_q + KW'(i_q);
          end
        end
        SCAN: state_q <= (k_q >= KW'(len_q)) ? FIN : SCHK;
        SCHK: begin
          if (!seg_rd_q) count_q <= count_q + CNT_W'(1);
          k_q     <= k_q + KW'(2);
          state_q <= SCAN;
        end
        FIN: if (res_ready_i) state_q <= IDLE;
        default: state_q <= IDLE;
      endcase
    end
  end

  assign busy_o                = state_q != IDLE;
  assign res_valid_o           = state_q == FIN;
  assign res_o.odd_prime_count = count_q;
  assign res_o.job_error       = err_q;

endmodule
`default_nettype wire

// ===== src/segmented_prime_sieve_counter.sv =====
// top level of the segmented prime sieve counter
`default_nettype none
// One request is one job; the block takes a new job only after the previous one has left
// the sequencer. A job runs a root search, the segment division, a clearing pass over both
// mark memories, then for every odd i up to r a base lookup plus, for each unmarked i, the
// marking of its base multiples, the offset division and the marking of its segment
// multiples, and finally a scan over the odd candidates of the segment. The single write
// port of each mark memory and the shared divider set the pace of these steps; a job with a
// bad index skips them and goes straight to its result.
module segmented_prime_sieve_counter import sps_pkg::*; #(
  parameter int BASE_DEPTH    = BASE_DEPTH_DEF,
  parameter int SEGMENT_DEPTH = SEGMENT_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  logic      busy, res_valid, res_ready;
  out_item_t res;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      out_valid_q;
  out_item_t out_data_q;

  sps_engine #(
    .BASE_DEPTH    (BASE_DEPTH),
    .SEGMENT_DEPTH (SEGMENT_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .job_i       (in_data_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  sps_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign res_ready = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready) out_data_q <= res;
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ===== src/sps_checker.sv =====
// port level checks of the segmented prime sieve counter
`default_nettype none
module sps_checker import sps_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.job_error |-> out_data_o.odd_prime_count == '0)
    else $error("rejected job with nonzero count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("no stall after a request was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_bad_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    ({1'b0, in_data_i.segment_index} >= in_data_i.segment_total) |=> in_stall_o)
    else $error("bad index request not held");

endmodule

bind segmented_prime_sieve_counter sps_checker u_chk (.*);
`default_nettype wire
